// File: rtl/gray_header_payload_vote_select_macros.svh
// Assertion macros for the gray header payload vote select block.
`ifndef GRAY_HEADER_PAYLOAD_VOTE_SELECT_MACROS_SVH
`define GRAY_HEADER_PAYLOAD_VOTE_SELECT_MACROS_SVH

`ifndef SYNTHESIS

// Implication checked at the same edge.
`define GHPVS_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("ghpvs assertion failed");

// Consequent checked in the cycle after the antecedent.
`define GHPVS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ghpvs assertion failed");

`else

`define GHPVS_ASSERT(label, clk, rst, prop)
`define GHPVS_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: rtl/ghpvs_pkg.sv
// Package: payload structs, register map and decode result type.
package ghpvs_pkg;

  localparam int VEC_W   = 64;
  localparam int LEN_W   = 7;
  localparam int PB_W    = 7;
  localparam int START_W = 6;
  localparam int SCORE_W = 7;
  localparam int INDEX_W = 8;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // Word index of each configuration register (byte address / 4).
  localparam logic REG_PAYLOAD_BITS = 1'b0;

  localparam logic [PB_W-1:0] PAYLOAD_BITS_RESET = 7'd8;

  typedef struct packed {
    logic [VEC_W-1:0] activation_bits;
    logic [LEN_W-1:0] activation_length;
    logic             last_in_list;
  } ghpvs_item_t;

  typedef struct packed {
    logic               hdr_fits;
    logic [START_W-1:0] pl_offset;
    logic [VEC_W-1:0]   payload_value;
    logic [SCORE_W-1:0] score_count;
    logic               selection_done;
    logic               selection_found;
    logic [INDEX_W-1:0] win_index;
    logic               list_overflow;
  } ghpvs_result_t;

  typedef struct packed {
    logic               hdr_fits;
    logic [START_W-1:0] pl_offset;
    logic [VEC_W-1:0]   payload_value;
    logic [SCORE_W-1:0] score_count;
  } ghpvs_dec_t;

endpackage

// File: rtl/ghpvs_decode.sv
// Header decode: length mask, Gray offset decode, payload extract and score popcount.
module ghpvs_decode #(
  parameter int HEADER_BITS = 6,
  parameter int SCORE_BITS  = 8,
  parameter int VECTOR_BITS = 64
) (
  input  ghpvs_pkg::ghpvs_item_t            item,
  input  logic [ghpvs_pkg::PB_W-1:0]        payload_bits,
  output ghpvs_pkg::ghpvs_dec_t             dec
);
  import ghpvs_pkg::*;

  localparam logic [VEC_W-1:0] SCORE_MASK =
    (SCORE_BITS >= VEC_W) ? {VEC_W{1'b1}} : ((64'd1 << SCORE_BITS) - 64'd1);

  logic [LEN_W-1:0]       len_c;
  logic [VEC_W-1:0]       len_mask;
  logic [VEC_W-1:0]       pb_mask;
  logic [VEC_W-1:0]       vec;
  logic [HEADER_BITS-1:0] gray;
  logic [HEADER_BITS-1:0] bin;
  logic [START_W-1:0]     start;
  logic [VEC_W-1:0]       shifted;
  logic                   fits;
  logic [VEC_W-1:0]       payload;

  always_comb begin
    len_c = (item.activation_length > LEN_W'(VECTOR_BITS)) ?
            LEN_W'(VECTOR_BITS) : item.activation_length;
    for (int i = 0; i < VEC_W; i++) begin
      len_mask[i] = LEN_W'(i) < len_c;
      pb_mask[i]  = PB_W'(i) < payload_bits;
    end
    vec  = item.activation_bits & len_mask;
    gray = vec[HEADER_BITS-1:0];
    for (int i = 0; i < HEADER_BITS; i++) begin
      bin[i] = ^(gray >> i);
    end
    start   = START_W'(bin);
    shifted = vec >> start;
    fits    = (payload_bits != '0) &&
              ((8'(start) + 8'(payload_bits)) <= 8'(len_c));
    payload = fits ? (shifted & pb_mask) : '0;

    dec.hdr_fits      = fits;
    dec.pl_offset     = start;
    dec.payload_value = payload;
    dec.score_count   = SCORE_W'($countones(payload & SCORE_MASK));
  end

endmodule

// File: rtl/gray_header_payload_vote_select.sv
// An accepted item passes the input register, then the result register, to result valid.
// Throughput: one item per cycle unless result_ready stalls; decode and the best-score compare sit in one stage.
// A stalled result holds while the input register still takes one more item.
// Reset (synchronous, active high) clears valids, list position, best tracking
// and sets payload_bits to 8.
module gray_header_payload_vote_select #(
  parameter int HEADER_BITS    = 6,
  parameter int SCORE_BITS     = 8,
  parameter int VECTOR_BITS    = 64,
  parameter int MAX_CANDIDATES = 256
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_ready,
  input  ghpvs_pkg::ghpvs_item_t            item,
  output logic                              result_valid,
  input  logic                              result_ready,
  output ghpvs_pkg::ghpvs_result_t          result,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ghpvs_pkg::PADDR_W-1:0]     paddr,
  input  logic [ghpvs_pkg::PDATA_W-1:0]     pwdata,
  output logic [ghpvs_pkg::PDATA_W-1:0]     prdata,
  output logic                              pready
);
  import ghpvs_pkg::*;

`include "gray_header_payload_vote_select_macros.svh"

  localparam int POS_W = $clog2(MAX_CANDIDATES + 1);

  logic [PB_W-1:0]    payload_bits;
  logic               s1_valid;
  ghpvs_item_t        s1_item;
  logic               advance;
  ghpvs_dec_t         dec;

  logic [POS_W-1:0]   item_position;
  logic [SCORE_W-1:0] best_score;
  logic [INDEX_W-1:0] best_position;
  logic               found_any;

  logic [POS_W-1:0]   item_position_next;
  logic [SCORE_W-1:0] best_score_next;
  logic [INDEX_W-1:0] best_position_next;
  logic               found_any_next;
  ghpvs_result_t      result_next;

  logic               overflow;
  logic               take;
  logic               found_run;
  logic [INDEX_W-1:0] pos_run;
  logic               cfg_write;

  // Configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_PAYLOAD_BITS);
  assign prdata    = (paddr[2] == REG_PAYLOAD_BITS) ? PDATA_W'(payload_bits) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      payload_bits <= PAYLOAD_BITS_RESET;
    end else if (cfg_write) begin
      payload_bits <= pwdata[PB_W-1:0];
    end
  end

  // Pipeline control
  assign advance    = !result_valid || result_ready;
  assign item_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (item_ready) begin
        s1_valid <= item_valid;
      end
      if (advance) begin
        result_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      s1_item <= item;
    end
    if (advance && s1_valid) begin
      result <= result_next;
    end
  end

  ghpvs_decode #(
    .HEADER_BITS (HEADER_BITS),
    .SCORE_BITS  (SCORE_BITS),
    .VECTOR_BITS (VECTOR_BITS)
  ) u_decode (
    .item         (s1_item),
    .payload_bits (payload_bits),
    .dec          (dec)
  );

  // Running selection
  always_comb begin
    overflow  = item_position >= POS_W'(MAX_CANDIDATES);
    take      = dec.hdr_fits && !overflow &&
                (!found_any || (dec.score_count > best_score));
    found_run = found_any || take;
    pos_run   = take ? INDEX_W'(item_position) : best_position;

    result_next.hdr_fits        = dec.hdr_fits;
    result_next.pl_offset       = dec.pl_offset;
    result_next.payload_value   = dec.payload_value;
    result_next.score_count     = dec.score_count;
    result_next.selection_done  = s1_item.last_in_list;
    result_next.selection_found = found_run;
    result_next.win_index       = found_run ? pos_run : '0;
    result_next.list_overflow   = overflow;
  end

  always_comb begin
    if (s1_item.last_in_list) begin
      item_position_next = '0;
      best_score_next    = '0;
      best_position_next = '0;
      found_any_next     = 1'b0;
    end else begin
      item_position_next = overflow ? item_position : item_position + 1'b1;
      best_score_next    = take ? dec.score_count : best_score;
      best_position_next = pos_run;
      found_any_next     = found_run;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_position <= '0;
      best_score    <= '0;
      best_position <= '0;
      found_any     <= 1'b0;
    end else if (advance && s1_valid) begin
      item_position <= item_position_next;
      best_score    <= best_score_next;
      best_position <= best_position_next;
      found_any     <= found_any_next;
    end
  end

  // Checks
  `GHPVS_ASSERT(a_pos_bound, clk, rst, item_position <= POS_W'(MAX_CANDIDATES))
  `GHPVS_ASSERT(a_invalid_empty, clk, rst, result_valid && !result.hdr_fits |-> result.payload_value == '0 && result.score_count == '0)
  `GHPVS_ASSERT(a_none_found, clk, rst, result_valid && !result.selection_found |-> result.win_index == '0)
  `GHPVS_ASSERT_NEXT(a_list_clear, clk, rst, s1_valid && advance && s1_item.last_in_list, item_position == '0 && !found_any)

endmodule
